// ----- sv/depq_pkg.sv -----
package depq_pkg;

   localparam int ValueWidth = 32;
   localparam int OccWidth   = 7;

   typedef enum logic [1:0] {
      KIND_INSERT  = 2'd0,
      KIND_DEL_MAX = 2'd1,
      KIND_DEL_MIN = 2'd2,
      KIND_CLEAR   = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type                      kind;
      logic signed [ValueWidth-1:0]  value;
   } req_type;

   typedef struct packed {
      logic                          is_empty;
      logic signed [ValueWidth-1:0]  largest;
      logic signed [ValueWidth-1:0]  smallest;
      logic [OccWidth-1:0]           occupancy;
      logic                          insert_dropped;
   } rsp_type;

   // command broadcast to every cell of the chain
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DEL_MAX,
      CELL_DEL_MIN,
      CELL_CLEAR
   } cell_op_type;

   typedef struct packed {
      cell_op_type                   op;
      logic signed [ValueWidth-1:0]  value;
   } cell_ctl_type;

   // signed order as unsigned order
   function automatic logic key_greater(input logic [ValueWidth-1:0] a,
                                        input logic [ValueWidth-1:0] b);
      return {~a[ValueWidth-1], a[ValueWidth-2:0]} > {~b[ValueWidth-1], b[ValueWidth-2:0]};
   endfunction

endpackage

// ----- sv/depq_cell.sv -----
module depq_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  depq_pkg::cell_ctl_type            ctl,
   input  logic signed [depq_pkg::ValueWidth-1:0] left_val,
   input  logic                              left_valid,
   input  logic                              left_gt,
   input  logic signed [depq_pkg::ValueWidth-1:0] right_val,
   input  logic                              right_valid,
   output logic signed [depq_pkg::ValueWidth-1:0] val,
   output logic                              valid,
   output logic                              gt
);
   import depq_pkg::*;

   logic signed [ValueWidth-1:0] val_ff, val_in;
   logic                         valid_ff, valid_in;

   // this entry is held and lies above the incoming value
   assign gt    = valid_ff && key_greater(val_ff, ctl.value);
   assign val   = val_ff;
   assign valid = valid_ff;

   always_comb begin
      val_in   = val_ff;
      valid_in = valid_ff;
      case (ctl.op)
         CELL_INSERT: begin
            if (left_gt) begin
               // larger entries move up one place
               val_in   = left_val;
               valid_in = 1'b1;
            end else if (left_valid && (gt || !valid_ff)) begin
               val_in   = ctl.value;
               valid_in = 1'b1;
            end
         end
         CELL_DEL_MIN: begin
            val_in   = right_val;
            valid_in = right_valid;
         end
         CELL_DEL_MAX: begin
            valid_in = valid_ff && right_valid;
         end
         CELL_CLEAR: begin
            valid_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

// ----- sv/double_ended_priority_queue.sv -----
// the chain cells update at the accepting edge; the result register then loads the readout
// of the updated chain as soon as the output register is free or its item is taken
// throughput: one item per cycle; every operation is one step of the sorted cell chain
// a request is held off only while a finished result still waits on a stalled output
// reset: synchronous, active high; empties the chain (valid bits and count cleared),
// the held values themselves are not reset
module double_ended_priority_queue #(
   parameter int CAPACITY = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  depq_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output depq_pkg::rsp_type  rsp_data
);
   import depq_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);

   // per-cell wiring along the chain
   logic signed [ValueWidth-1:0] cell_val   [CAPACITY];
   logic                         cell_valid [CAPACITY];
   logic                         cell_gt    [CAPACITY];

   cell_ctl_type ctl;

   logic          accept;
   logic          load;
   logic          full;
   logic          pend_ff, pend_in;
   logic          drop_ff, drop_in;
   logic [CW-1:0] count_ff, count_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;
   logic signed [ValueWidth-1:0] top_val;

   // the last cell holds an entry only when every place is taken
   assign full = cell_valid[CAPACITY-1];

   // the result register takes the readout of the chain after the update, once the output is free
   assign load      = pend_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = pend_ff && !load;
   assign accept    = req_valid && !req_stall;

   // decode the request into a chain command
   always_comb begin
      ctl.value = req_data.value;
      ctl.op    = CELL_HOLD;
      drop_in   = drop_ff;
      count_in  = count_ff;
      if (accept) begin
         drop_in = 1'b0;
         case (req_data.kind)
            KIND_INSERT: begin
               if (full) begin
                  drop_in = 1'b1;
               end else begin
                  ctl.op   = CELL_INSERT;
                  count_in = count_ff + CW'(1);
               end
            end
            KIND_DEL_MAX: begin
               ctl.op = CELL_DEL_MAX;
               if (count_ff != '0) begin
                  count_in = count_ff - CW'(1);
               end
            end
            KIND_DEL_MIN: begin
               ctl.op = CELL_DEL_MIN;
               if (count_ff != '0) begin
                  count_in = count_ff - CW'(1);
               end
            end
            KIND_CLEAR: begin
               ctl.op   = CELL_CLEAR;
               count_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // sorted chain, smallest at cell 0, held entries packed from the bottom
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [ValueWidth-1:0] l_val, r_val;
      logic                         l_valid, l_gt, r_valid;

      if (i == 0) begin : g_bottom
         assign l_val   = cell_val[i];
         assign l_valid = 1'b1;
         assign l_gt    = 1'b0;
      end else begin : g_inner_l
         assign l_val   = cell_val[i-1];
         assign l_valid = cell_valid[i-1];
         assign l_gt    = cell_gt[i-1];
      end

      if (i == CAPACITY - 1) begin : g_top
         assign r_val   = cell_val[i];
         assign r_valid = 1'b0;
      end else begin : g_inner_r
         assign r_val   = cell_val[i+1];
         assign r_valid = cell_valid[i+1];
      end

      depq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .left_val    (l_val),
         .left_valid  (l_valid),
         .left_gt     (l_gt),
         .right_val   (r_val),
         .right_valid (r_valid),
         .val         (cell_val[i]),
         .valid       (cell_valid[i]),
         .gt          (cell_gt[i])
      );
   end

   // largest sits in the one cell whose upper neighbor is empty
   always_comb begin
      top_val = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (cell_valid[i] && (i == CAPACITY - 1 || !cell_valid[(i + 1) % CAPACITY])) begin
            top_val = top_val | cell_val[i];
         end
      end
   end

   // readout of the chain state left by the previous item
   always_comb begin
      rsp_in                = rsp_ff;
      rsp_valid_in          = rsp_valid_ff && rsp_stall;
      pend_in               = accept ? 1'b1 : (pend_ff && !load);
      if (load) begin
         rsp_valid_in          = 1'b1;
         rsp_in.is_empty       = !cell_valid[0];
         rsp_in.largest        = top_val;
         rsp_in.smallest       = cell_valid[0] ? cell_val[0] : '0;
         rsp_in.occupancy      = OccWidth'(count_ff);
         rsp_in.insert_dropped = drop_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      drop_ff <= drop_in;
      if (reset) begin
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- sim/testbench.sv -----
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import depq_pkg::*;

   localparam int Capacity      = 64;
   localparam int WatchdogLimit = 3000;   // cycles with no item moving on either side
   localparam int DrainCycles   = 6;      // idle margin after the last owed status item
   localparam int MaxReports    = 10;
   localparam int IntroHold     = 150;    // long output hold-off, in cycles

   typedef logic signed [ValueWidth-1:0] value_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   // sorted copy of what the queue should hold, smallest first
   value_type held_values[$];
   // status items still owed by the block, oldest first
   rsp_type   pending_status[$];

   int send_idle_pct;
   int recv_stall_pct;
   int hold_left;
   int mismatch_count;
   int inserts_done;
   int removals_done;
   int clears_done;
   int drops_done;
   int peak_occupancy;
   int status_checked;

   double_ended_priority_queue #(
      .CAPACITY(Capacity)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   // 4 ns clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // apply one command to the local copy and return the status it should produce
   function automatic rsp_type apply_command(input req_type item);
      rsp_type status;
      int      pos;
      status = '0;
      case (item.kind)
         KIND_INSERT: begin
            inserts_done++;
            if (held_values.size() >= Capacity) begin
               // full store: value dropped, contents unchanged
               status.insert_dropped = 1'b1;
               drops_done++;
            end else begin
               // new value goes after any equal entries
               pos = 0;
               while (pos < held_values.size() && held_values[pos] <= item.value) pos++;
               held_values.insert(pos, item.value);
            end
         end
         KIND_DEL_MAX: begin
            removals_done++;
            if (held_values.size() > 0) void'(held_values.pop_back());
         end
         KIND_DEL_MIN: begin
            removals_done++;
            if (held_values.size() > 0) void'(held_values.pop_front());
         end
         default: begin
            clears_done++;
            held_values.delete();
         end
      endcase
      if (held_values.size() == 0) begin
         // empty store reports zero for both ends
         status.is_empty = 1'b1;
      end else begin
         status.largest  = held_values[held_values.size()-1];
         status.smallest = held_values[0];
      end
      status.occupancy = OccWidth'(held_values.size());
      if (held_values.size() > peak_occupancy) peak_occupancy = held_values.size();
      return status;
   endfunction

   task automatic note_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MaxReports) $display("mismatch: %s", what);
   endtask

   // offer one item, with random idle cycles ahead of it, and wait until it is taken
   task automatic send_command(input kind_type kind, input value_type value);
      req_type item;
      item.kind  = kind;
      item.value = value;
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      // payload stays put while the block stalls it
      while (req_stall) @(posedge clock);
      pending_status.push_back(apply_command(item));
   endtask

   // values leaning toward the extremes and toward repeats
   function automatic value_type random_value();
      case ($urandom_range(9))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7FFF_FFFF;
         2, 3, 4: return value_type'($urandom_range(8)) - 32'sd4;
         5:       return $urandom_range(1) ? 32'sd0 : -32'sd1;
         default: return value_type'($urandom);
      endcase
   endfunction

   // receiver side: random stalls, or a long hold-off when one is requested
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   // compare every taken status item with the oldest one owed
   always @(posedge clock) begin : check_status
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_status.size() == 0) begin
            note_mismatch($sformatf("unexpected item empty=%0b max=%0d min=%0d occ=%0d drop=%0b",
               rsp_data.is_empty, rsp_data.largest, rsp_data.smallest,
               rsp_data.occupancy, rsp_data.insert_dropped));
         end else begin
            want = pending_status.pop_front();
            status_checked++;
            if (want.is_empty !== rsp_data.is_empty || want.largest !== rsp_data.largest ||
                want.smallest !== rsp_data.smallest || want.occupancy !== rsp_data.occupancy ||
                want.insert_dropped !== rsp_data.insert_dropped) begin
               note_mismatch({
                  $sformatf("expected empty=%0b max=%0d min=%0d occ=%0d drop=%0b, ",
                     want.is_empty, want.largest, want.smallest, want.occupancy,
                     want.insert_dropped),
                  $sformatf("got empty=%0b max=%0d min=%0d occ=%0d drop=%0b",
                     rsp_data.is_empty, rsp_data.largest, rsp_data.smallest,
                     rsp_data.occupancy, rsp_data.insert_dropped)});
            end
         end
      end
   end

   // watchdog: too long with nothing moving ends the run
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WatchdogLimit) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("timeout: no item moved for %0d cycles", WatchdogLimit);
      $display("FAILED: results differ");
      $finish;
   end

   // empty-store removals, the value extremes, duplicates and clears
   task automatic test_empty_and_extremes();
      send_command(KIND_DEL_MAX, 32'sd0);
      send_command(KIND_DEL_MIN, 32'sd0);
      send_command(KIND_CLEAR,   32'sd0);
      send_command(KIND_INSERT,  32'sh7FFF_FFFF);
      send_command(KIND_INSERT,  32'sh8000_0000);
      send_command(KIND_INSERT,  32'sd0);
      send_command(KIND_INSERT,  -32'sd1);
      send_command(KIND_INSERT,  32'sd1);
      // three equal copies, removals take one at a time
      send_command(KIND_INSERT,  32'sd5);
      send_command(KIND_INSERT,  32'sd5);
      send_command(KIND_INSERT,  32'sd5);
      send_command(KIND_DEL_MAX, 32'sh7FFF_FFFF);
      send_command(KIND_DEL_MAX, 32'sd5);
      send_command(KIND_DEL_MIN, 32'sh8000_0000);
      send_command(KIND_DEL_MIN, -32'sd1);
      // clear ignores its value field
      send_command(KIND_CLEAR,   32'shFFFF_FFFF);
      // single entry: both ends are the same value
      send_command(KIND_INSERT,  -32'sd7);
      send_command(KIND_DEL_MIN, 32'sd0);
      send_command(KIND_DEL_MAX, 32'sd0);
      send_command(KIND_INSERT,  32'shAAAA_AAAA);
      send_command(KIND_INSERT,  32'sh5555_5555);
      send_command(KIND_CLEAR,   32'sd0);
   endtask

   // fill to capacity, then inserts are dropped until room is made
   task automatic test_full_store();
      send_command(KIND_CLEAR, value_type'($urandom));
      repeat (Capacity) send_command(KIND_INSERT, random_value());
      send_command(KIND_INSERT,  32'sh7FFF_FFFF);
      send_command(KIND_INSERT,  32'sh8000_0000);
      send_command(KIND_DEL_MIN, value_type'($urandom));
      send_command(KIND_INSERT,  random_value());
      send_command(KIND_INSERT,  random_value());
      send_command(KIND_DEL_MAX, value_type'($urandom));
      send_command(KIND_DEL_MAX, value_type'($urandom));
      send_command(KIND_CLEAR,   value_type'($urandom));
   endtask

   // random commands in fill and drain bursts so the store swings from empty to full
   task automatic test_random_mix(input int count, input int send_pct, input int recv_pct);
      int       sent;
      int       burst_left;
      int       insert_pct;
      int       pick;
      kind_type kind;
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      sent       = 0;
      burst_left = 0;
      insert_pct = 50;
      while (sent < count) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(96, 16);
            insert_pct = $urandom_range(1) ? 85 : 20;
         end
         burst_left--;
         pick = $urandom_range(99);
         if (pick < 2)
            kind = KIND_CLEAR;
         else if (pick < 2 + insert_pct)
            kind = KIND_INSERT;
         else
            kind = $urandom_range(1) ? KIND_DEL_MAX : KIND_DEL_MIN;
         send_command(kind, random_value());
         sent++;
      end
   endtask

   // long receiver hold-off while items keep coming, so the block stalls its input
   task automatic test_output_hold_off();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_left      = IntroHold;
      repeat (30) send_command($urandom_range(3) == 0 ? KIND_DEL_MIN : KIND_INSERT,
                               random_value());
   endtask

   initial begin
      req_valid      <= 1'b0;
      req_data       <= '0;
      reset          <= 1'b1;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_left      = 0;
      mismatch_count = 0;
      inserts_done   = 0;
      removals_done  = 0;
      clears_done    = 0;
      drops_done     = 0;
      peak_occupancy = 0;
      status_checked = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_and_extremes();
      test_full_store();
      // no idling, sender idle, receiver stalling, both
      test_random_mix(110, 0, 0);
      test_random_mix(110, 52, 0);
      test_random_mix(110, 0, 52);
      test_random_mix(110, 15, 15);
      test_output_hold_off();

      req_valid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("covered %0d inserts (%0d dropped on a full store), %0d removals, %0d clears",
               inserts_done, drops_done, removals_done, clears_done);
      $display("checked %0d status items, peak occupancy %0d of %0d",
               status_checked, peak_occupancy, Capacity);
      if (mismatch_count == 0 && pending_status.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d mismatches, %0d items never returned", mismatch_count,
                  pending_status.size());
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
